// ===== rtl/pctl_pkg.sv =====
// Shared types and constants of the timed PID controller.
package pctl_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int MUL_STEPS = 32;   // one bit of elapsed time per step
  localparam int DIV_STEPS = 43;   // quotient bits of |num| >> 16 over elapsed
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP     = 8'd3;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_p;
    logic mul_i;
    logic mul_d;
    logic load_d;
    logic iter;
    logic sum;
    logic clamp;
    logic drive;
    logic emit;
  } pctl_cmd_t;

  typedef struct packed {
    logic time_seen;
    logic el_zero;
    logic iter_done;
    logic out_free;
  } pctl_sts_t;

endpackage

// ===== rtl/pctl_ctrl.sv =====
// Sequencer of the timed PID controller.
module pctl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output pctl_pkg::pctl_cmd_t cmd,
  input  pctl_pkg::pctl_sts_t sts
);
  import pctl_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PREP  = 11'b00000000010,
    S_MULP  = 11'b00000000100,
    S_MULI  = 11'b00000001000,
    S_MULD  = 11'b00000010000,
    S_LOADD = 11'b00000100000,
    S_ITER  = 11'b00001000000,
    S_SUM   = 11'b00010000000,
    S_CLAMP = 11'b00100000000,
    S_DRIVE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        // first sample only records its time
        state_next = sts.time_seen ? S_MULP : S_DONE;
      end
      S_MULP: begin
        cmd.mul_p  = 1'b1;
        state_next = S_MULI;
      end
      S_MULI: begin
        cmd.mul_i  = 1'b1;
        state_next = sts.el_zero ? S_DONE : S_MULD;
      end
      S_MULD: begin
        cmd.mul_d  = 1'b1;
        state_next = S_LOADD;
      end
      S_LOADD: begin
        cmd.load_d = 1'b1;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_done) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_DRIVE;
      end
      S_DRIVE: begin
        cmd.drive  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pctl_dp.sv =====
// Datapath of the timed PID controller: registers, shared multiplier, serial units.
module pctl_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  pctl_pkg::pctl_cmd_t            cmd,
  output pctl_pkg::pctl_sts_t            sts,
  input  logic [95:0]                    s_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pctl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [127:0]                   m_tdata
);
  import pctl_pkg::*;

  localparam logic signed [63:0] MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] MIN64 = -64'sd2147483648;

  function automatic logic [31:0] sat_mag(input logic neg, input logic [71:0] m);
    if (!neg) begin
      return (m > 72'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end else begin
      return (m > 72'h80000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > MAX64) begin
      return 32'h7FFFFFFF;
    end else if (x < MIN64) begin
      return 32'h80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // configuration
  logic signed [23:0] kp, ki, kd;
  logic [30:0]        wlim;

  // item and state
  logic signed [31:0] in_tgt, in_meas;
  logic [31:0]        in_time;
  logic signed [31:0] integ, prev_err, prev_tgt;
  logic [31:0]        prev_time;
  logic               seen;

  logic signed [31:0] err;
  logic [31:0]        el;
  logic signed [32:0] dt;
  logic signed [34:0] delta;
  logic signed [58:0] prod;
  logic [55:0]        mcand;
  logic [87:0]        mp;
  logic               i_neg, d_neg;
  logic [42:0]        dq;
  logic [31:0]        drem;
  logic [CNT_W-1:0]   cnt;
  logic signed [63:0] sum64;
  logic signed [31:0] p_val, i_val, d_val, drive_val;

  // combinational helpers
  logic signed [32:0] diff33;
  logic signed [31:0] err_next;
  logic signed [23:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [58:0] prod_next;
  logic [58:0]        prod_mag;
  logic [56:0]        acc_sum;
  logic [32:0]        dsh, dsub;
  logic               dge;
  logic [71:0]        pr16;
  logic [63:0]        r64, inc;
  logic signed [63:0] wl64, clamp_s, drive_sum;
  logic signed [34:0] e1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      kd   <= '0;
      wlim <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  kp   <= cfg_data[23:0];
        REG_INTEG_GAIN: ki   <= cfg_data[23:0];
        REG_DERIV_GAIN: kd   <= cfg_data[23:0];
        REG_WINDUP:     wlim <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign diff33   = 33'(in_tgt) - 33'(in_meas);
  assign err_next = (diff33[32] != diff33[31]) ?
                    (diff33[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : diff33[31:0];

  always_comb begin
    mul_a = kp;
    mul_b = 35'(err);
    if (cmd.mul_i) begin
      mul_a = ki;
    end else if (cmd.mul_d) begin
      mul_a = kd;
      mul_b = delta;
    end
  end

  assign prod_next = mul_a * mul_b;
  assign prod_mag  = prod[58] ? (~prod + 59'd1) : prod;
  assign e1        = 35'(err) - 35'(prev_err);

  assign acc_sum = {1'b0, mp[87:32]} + (mp[0] ? {1'b0, mcand} : 57'd0);
  assign dsh     = {drem, dq[42]};
  assign dge     = (dsh >= {1'b0, el});
  assign dsub    = dsh - {1'b0, el};

  // rounded-toward-zero magnitude of the integral increment, capped at 2^62
  assign pr16 = mp[87:16];
  assign r64  = (pr16 > (72'd1 << 62)) ? (64'd1 << 62) : pr16[63:0];
  assign inc  = i_neg ? (~r64 + 64'd1) : r64;

  assign wl64 = {33'd0, wlim};
  always_comb begin
    clamp_s = sum64;
    if (wlim != '0) begin
      if (clamp_s > wl64) clamp_s = wl64;
      if (clamp_s < -wl64) clamp_s = -wl64;
    end
  end

  assign drive_sum = 64'(p_val) + 64'(i_val) + 64'(d_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      prev_err  <= '0;
      prev_tgt  <= '0;
      prev_time <= '0;
      seen      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.prep && !seen) begin
        seen      <= 1'b1;
        prev_time <= in_time;
      end
      if (cmd.load_d) begin
        cnt <= '0;
      end else if (cmd.iter) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.clamp) begin
        integ     <= sat32(clamp_s);
        prev_err  <= err;
        prev_tgt  <= in_tgt;
        prev_time <= in_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_tgt  <= s_tdata[31:0];
      in_meas <= s_tdata[63:32];
      in_time <= s_tdata[95:64];
    end
    if (cmd.prep) begin
      err <= err_next;
      el  <= in_time - prev_time;
      dt  <= 33'(in_tgt) - 33'(prev_tgt);
      if (!seen) begin
        p_val     <= '0;
        i_val     <= '0;
        d_val     <= '0;
        drive_val <= '0;
      end
    end
    if (cmd.mul_p || cmd.mul_i || cmd.mul_d) begin
      prod <= prod_next;
    end
    if (cmd.mul_p) begin
      delta <= e1 - 35'(dt);
    end
    if (cmd.mul_i) begin
      p_val <= sat_mag(prod[58], {29'd0, prod_mag[58:16]});
      if (el == '0) begin
        i_val     <= '0;
        d_val     <= '0;
        drive_val <= '0;
      end
    end
    if (cmd.mul_d) begin
      mcand <= prod_mag[55:0];
      i_neg <= prod[58];
      mp    <= {56'd0, el};
    end
    if (cmd.load_d) begin
      dq    <= prod_mag[58:16];
      d_neg <= prod[58];
      drem  <= '0;
    end
    if (cmd.iter) begin
      if (cnt < CNT_W'(MUL_STEPS)) begin
        mp <= {acc_sum, mp[31:1]};
      end
      drem <= dge ? dsub[31:0] : dsh[31:0];
      dq   <= {dq[41:0], dge};
    end
    if (cmd.sum) begin
      sum64 <= 64'(integ) + $signed(inc);
    end
    if (cmd.clamp) begin
      i_val <= sat32(clamp_s);
      d_val <= sat_mag(d_neg, {29'd0, dq});
    end
    if (cmd.drive) begin
      drive_val <= sat32(drive_sum);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {d_val, i_val, p_val, drive_val};
    end
  end

  assign sts.time_seen = seen;
  assign sts.el_zero   = (el == '0);
  assign sts.iter_done = (cnt == CNT_W'(DIV_STEPS - 1));
  assign sts.out_free  = !m_tvalid || m_tready;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken beat");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    cmd.iter |-> (cnt < CNT_W'(DIV_STEPS)) && (el != '0))
    else $error("iteration outside its range");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.iter |-> (drem < el))
    else $error("divider remainder not below divisor");

  a_first_seen: assert property (@(posedge clk) disable iff (rst)
    (cmd.prep && !seen) |=> seen)
    else $error("first sample not recorded");
`endif

endmodule

// ===== rtl/pid_controller_timed_antiwindup.sv =====
// Top level of the timed PID controller with integral clamp.
//
// Input beats on s_t*: target, measured and a microsecond timestamp. Each beat
// gives one output beat on m_t* with drive and its P, I and D terms, Q16.16.
// Gains and the windup clamp are to be written on the cfg_* port while idle;
// the block does not enforce this. cfg_ready is always high and writes to unknown
// indexes are dropped. The first beat after reset only records its timestamp
// and returns zeros. A beat with zero elapsed time returns only its P term,
// with drive, I and D at zero. In a full update a shared 24x35 multiplier runs
// three products, then a shift-add multiplier (32 steps) scales the integral
// by elapsed time while a restoring divider (43 steps) divides the derivative
// by it. One item is in work at a time; the next beat is accepted in the cycle
// after the result is loaded.
// The result sits in an output register: while the receiver stalls, the next
// input beat is still accepted and worked on, and it waits for that register.
// Synchronous reset clears the gains, the integral, the history and both
// channels' valid state.
module pid_controller_timed_antiwindup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [95:0]                    s_tdata,   // target, measured, sample_time
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [127:0]                   m_tdata,   // drive, p_term, i_term, d_term
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pctl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import pctl_pkg::*;

  pctl_cmd_t cmd;
  pctl_sts_t sts;

  pctl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pctl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
